/* sv/epu_pkg.sv */
// Package for the epicycle particle update: fixed-point constants, register indexes
// and saturating arithmetic helpers. No dependencies.
package epu_pkg;

  localparam int unsigned FracBits = 32;
  localparam int unsigned WordW    = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RateW    = 63;

  typedef enum logic [CfgIdxW-1:0] {
    RegOrbitRate  = 3'd0,
    RegVertRate   = 3'd1,
    RegStepTime   = 3'd2,
    RegSinHalfP   = 3'd3,
    RegTanQuartP  = 3'd4,
    RegSinHalfV   = 3'd5,
    RegTanQuartV  = 3'd6
  } cfg_reg_e;

  localparam logic signed [WordW-1:0] SMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] SMin = {1'b1, {(WordW-1){1'b0}}};

  function automatic logic signed [WordW-1:0] sadd(input logic signed [WordW-1:0] a,
                                                   input logic signed [WordW-1:0] b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) begin
      return s[WordW] ? SMin : SMax;
    end
    return s[WordW-1:0];
  endfunction

  function automatic logic signed [WordW-1:0] ssub(input logic signed [WordW-1:0] a,
                                                   input logic signed [WordW-1:0] b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) begin
      return s[WordW] ? SMin : SMax;
    end
    return s[WordW-1:0];
  endfunction

  function automatic logic signed [WordW-1:0] dbl(input logic signed [WordW-1:0] a);
    return sadd(a, a);
  endfunction

endpackage

/* sv/epu_fmul.sv */
// Pipelined Q.F multiplier with round-half-away and saturation.
// Depends on epu_pkg. Enable stalls all stages.
module epu_fmul #(
  parameter int unsigned FRAC_BITS = epu_pkg::FracBits
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [epu_pkg::WordW-1:0] a_i,
  input  logic signed [epu_pkg::WordW-1:0] b_i,
  output logic signed [epu_pkg::WordW-1:0] p_o
);
  import epu_pkg::*;

  localparam int unsigned HW = WordW / 2;

  logic [WordW-1:0] ma_d, mb_d;
  logic [WordW-1:0] ma_q, mb_q;
  logic             neg1_q, neg2_q;
  logic [WordW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [2*WordW-1:0] full, rnd, sh;
  logic signed [WordW-1:0] p_d, p_q;

  assign ma_d = a_i[WordW-1] ? (~a_i + 1'b1) : a_i;
  assign mb_d = b_i[WordW-1] ? (~b_i + 1'b1) : b_i;

  // Four 32x32 partial products in the second stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= ma_d;
      mb_q   <= mb_d;
      neg1_q <= a_i[WordW-1] ^ b_i[WordW-1];
      p00_q  <= ma_q[HW-1:0]     * mb_q[HW-1:0];
      p01_q  <= ma_q[HW-1:0]     * mb_q[WordW-1:HW];
      p10_q  <= ma_q[WordW-1:HW] * mb_q[HW-1:0];
      p11_q  <= ma_q[WordW-1:HW] * mb_q[WordW-1:HW];
      neg2_q <= neg1_q;
      p_q    <= p_d;
    end
  end

  always_comb begin
    full = {p11_q, p00_q} + ({{HW{1'b0}}, p01_q, {HW{1'b0}}})
         + ({{HW{1'b0}}, p10_q, {HW{1'b0}}});
    rnd  = full + ({{(2*WordW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
    sh   = rnd >> FRAC_BITS;
    if (!neg2_q) begin
      p_d = (sh[2*WordW-1:WordW-1] != '0) ? SMax : sh[WordW-1:0];
    end else if (sh[2*WordW-1:WordW] != '0 ||
                 sh[WordW-1:0] > {1'b1, {(WordW-1){1'b0}}}) begin
      p_d = SMin;
    end else begin
      p_d = ~sh[WordW-1:0] + 1'b1;
    end
  end

  assign p_o = p_q;
endmodule

/* sv/epu_fdiv.sv */
// Pipelined restoring divider: num * 2^F / den, rounded half away, saturated.
// Depends on epu_pkg. One quotient bit per stage, 128 stages between an input and an
// output register; enable stalls all.
module epu_fdiv #(
  parameter int unsigned FRAC_BITS = epu_pkg::FracBits
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [epu_pkg::WordW-1:0] num_i,
  input  logic        [epu_pkg::RateW-1:0] den_i,
  output logic signed [epu_pkg::WordW-1:0] q_o
);
  import epu_pkg::*;

  localparam int unsigned NB = 2 * WordW;
  localparam int unsigned RW = RateW + 1;

  logic [NB-1:0] n_q [NB+1];
  logic [NB-1:0] qt_q [NB+1];
  logic [RW-1:0] r_q [NB+1];
  logic [RateW-1:0] d_q [NB+1];
  logic neg_q [NB+1];
  logic zero_q [NB+1];
  logic nz_q [NB+1];
  logic [WordW-1:0] m;
  logic signed [WordW-1:0] q_d, q_q;
  logic [NB-1:0] qr;

  assign m = num_i[WordW-1] ? (~num_i + 1'b1) : num_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= {{(NB-WordW){1'b0}}, m} << FRAC_BITS;
      qt_q[0]   <= '0;
      r_q[0]    <= '0;
      d_q[0]    <= den_i;
      neg_q[0]  <= num_i[WordW-1];
      zero_q[0] <= (den_i == '0);
      nz_q[0]   <= (num_i != '0);
    end
  end

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [RW:0] t;
    assign t = {r_q[s], n_q[s][NB-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1]    <= n_q[s] << 1;
        d_q[s+1]    <= d_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
        nz_q[s+1]   <= nz_q[s];
        if (t >= {2'b00, d_q[s]}) begin
          r_q[s+1]  <= RW'(t - {2'b00, d_q[s]});
          qt_q[s+1] <= {qt_q[s][NB-2:0], 1'b1};
        end else begin
          r_q[s+1]  <= t[RW-1:0];
          qt_q[s+1] <= {qt_q[s][NB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    qr = qt_q[NB] + {{(NB-1){1'b0}},
                     (r_q[NB] >= ({1'b0, d_q[NB]} - r_q[NB]))};
    if (zero_q[NB]) begin
      q_d = !nz_q[NB] ? '0 : (neg_q[NB] ? SMin : SMax);
    end else if (!neg_q[NB]) begin
      q_d = (qr[NB-1:WordW-1] != '0) ? SMax : qr[WordW-1:0];
    end else if (qr[NB-1:WordW] != '0 || qr[WordW-1:0] > {1'b1, {(WordW-1){1'b0}}}) begin
      q_d = SMin;
    end else begin
      q_d = ~qr[WordW-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

/* sv/epicycle_particle_update.sv */
// Top level of the epicycle particle update: config registers, pipeline control,
// and the dataflow of kick, shears and divides. Depends on epu_pkg, epu_fmul, epu_fdiv.
//
//  channel | handshake          | payload
//  cfg     | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//  in      | in_valid_i/ready_o | opcode_i, pos_*_i, vel_*_i, acc_*_i
//  out     | out_valid_o/ready_i| new_pos_*_o, new_vel_*_o
//
// One particle enters per cycle while the output is not stalled; the pipeline has
// Lat = 148 register stages: 18 for six rounds of multiplies and 130 for the divider
// (an input register, 128 one-bit quotient stages and an output register). The whole
// pipeline advances together; a stalled output freezes every stage, so nothing is
// lost or repeated. Register writes wait until the pipeline is empty and no input
// transaction is offered. Reset clears the valid bits and the other registers, but
// sets the orbit and vertical rates to 1.0.
module epicycle_particle_update #(
  parameter int unsigned FRAC_BITS = epu_pkg::FracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [epu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [epu_pkg::WordW-1:0]   cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic opcode_i,
  input  logic signed [epu_pkg::WordW-1:0] pos_x_i, pos_y_i, pos_z_i,
  input  logic signed [epu_pkg::WordW-1:0] vel_x_i, vel_y_i, vel_z_i,
  input  logic signed [epu_pkg::WordW-1:0] acc_x_i, acc_y_i, acc_z_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [epu_pkg::WordW-1:0] new_pos_x_o, new_pos_y_o, new_pos_z_o,
  output logic signed [epu_pkg::WordW-1:0] new_vel_x_o, new_vel_y_o, new_vel_z_o
);
  import epu_pkg::*;

  localparam int unsigned ML  = 3;          // multiplier latency
  localparam int unsigned DL  = 2*WordW + 2; // divider latency
  // Dataflow timeline, in cycles after entry.
  localparam int unsigned TK  = ML;          // kicked velocities
  localparam int unsigned TZ1 = TK + ML;     // zt1, xo, yo
  localparam int unsigned TZ2 = TZ1 + ML;    // zyt, ys
  localparam int unsigned TZ3 = TZ2 + ML;    // zxt, xst1
  localparam int unsigned TP2 = TZ3 + ML;    // yst
  localparam int unsigned TP3 = TP2 + ML;    // xst
  localparam int unsigned Lat = TP3 + DL;
  localparam logic signed [WordW-1:0] C34  = WordW'(3) << (FRAC_BITS - 2);
  localparam logic signed [WordW-1:0] C32  = WordW'(3) << (FRAC_BITS - 1);
  localparam logic signed [WordW-1:0] Half = WordW'(1) << (FRAC_BITS - 1);

  typedef logic signed [WordW-1:0] word_t;

  logic [RateW-1:0] orbit_q, vert_q, dt_q;
  word_t shp_q, tqp_q, shv_q, tqv_q;
  logic en;
  logic [Lat-1:0] vld_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  // Registers only change while no particle is in flight or being offered.
  assign cfg_ready_o = (vld_q == '0) && !in_valid_i;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orbit_q <= RateW'(1) << FRAC_BITS;
      vert_q  <= RateW'(1) << FRAC_BITS;
      dt_q    <= '0;
      shp_q   <= '0;
      tqp_q   <= '0;
      shv_q   <= '0;
      tqv_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegOrbitRate: orbit_q <= cfg_data_i[RateW-1:0];
        RegVertRate:  vert_q  <= cfg_data_i[RateW-1:0];
        RegStepTime:  dt_q    <= cfg_data_i[RateW-1:0];
        RegSinHalfP:  shp_q   <= word_t'({{30{cfg_data_i[33]}}, cfg_data_i[33:0]});
        RegTanQuartP: tqp_q   <= word_t'({{28{cfg_data_i[35]}}, cfg_data_i[35:0]});
        RegSinHalfV:  shv_q   <= word_t'({{30{cfg_data_i[33]}}, cfg_data_i[33:0]});
        RegTanQuartV: tqv_q   <= word_t'({{28{cfg_data_i[35]}}, cfg_data_i[35:0]});
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  word_t dt_w, om_w, oz_w;
  assign dt_w = {1'b0, dt_q};
  assign om_w = {1'b0, orbit_q};
  assign oz_w = {1'b0, vert_q};

  // Delay lines for values that wait on later products.
  word_t x_dl [TK+1];
  word_t y_dl [TK+1];
  word_t z_dl [TK+1];
  word_t vx_dl [TK+1];
  word_t vy_dl [TK+1];
  word_t vz_dl [TK+1];
  logic  op_dl [TK+1];
  assign x_dl[0] = pos_x_i;
  assign y_dl[0] = pos_y_i;
  assign z_dl[0] = pos_z_i;
  assign vx_dl[0] = vel_x_i;
  assign vy_dl[0] = vel_y_i;
  assign vz_dl[0] = vel_z_i;
  assign op_dl[0] = opcode_i;
  for (genvar i = 0; i < TK; i++) begin : g_in_dl
    always_ff @(posedge clk_i) begin
      if (en) begin
        x_dl[i+1]  <= x_dl[i];
        y_dl[i+1]  <= y_dl[i];
        z_dl[i+1]  <= z_dl[i];
        vx_dl[i+1] <= vx_dl[i];
        vy_dl[i+1] <= vy_dl[i];
        vz_dl[i+1] <= vz_dl[i];
        op_dl[i+1] <= op_dl[i];
      end
    end
  end

  // Kick.
  word_t kx, ky, kz, vxk, vyk, vzk;
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_kx (.clk_i, .en_i(en), .a_i(acc_x_i), .b_i(dt_w), .p_o(kx));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_ky (.clk_i, .en_i(en), .a_i(acc_y_i), .b_i(dt_w), .p_o(ky));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_kz (.clk_i, .en_i(en), .a_i(acc_z_i), .b_i(dt_w), .p_o(kz));
  assign vxk = op_dl[TK] ? sadd(vx_dl[TK], kx) : vx_dl[TK];
  assign vyk = op_dl[TK] ? sadd(vy_dl[TK], ky) : vy_dl[TK];
  assign vzk = op_dl[TK] ? sadd(vz_dl[TK], kz) : vz_dl[TK];

  // Stage A (TK -> TZ1): zx, tqv*vz, xo, yo.
  word_t zx, tvz, xo, yo, vx_a_q [ML], vy_a_q [ML], vz_a_q [ML];
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_zx (.clk_i, .en_i(en), .a_i(z_dl[TK]), .b_i(oz_w), .p_o(zx));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_tvz (.clk_i, .en_i(en), .a_i(tqv_q), .b_i(vzk), .p_o(tvz));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_xo (.clk_i, .en_i(en), .a_i(x_dl[TK]), .b_i(om_w), .p_o(xo));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_yo (.clk_i, .en_i(en), .a_i(y_dl[TK]), .b_i(om_w), .p_o(yo));
  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_a_q[0] <= vxk;
      vy_a_q[0] <= vyk;
      vz_a_q[0] <= vzk;
      for (int i = 1; i < ML; i++) begin
        vx_a_q[i] <= vx_a_q[i-1];
        vy_a_q[i] <= vy_a_q[i-1];
        vz_a_q[i] <= vz_a_q[i-1];
      end
    end
  end

  word_t zt1, ao, bo, xs, ysarg;
  assign zt1   = ssub(zx, tvz);
  assign ao    = sadd(dbl(vy_a_q[ML-1]), dbl(dbl(xo)));
  assign bo    = ssub(yo, dbl(vx_a_q[ML-1]));
  assign xs    = ssub(xo, ao);
  assign ysarg = ssub(yo, bo);

  // Stage B (TZ1 -> TZ2): shv*zt1, ys, c34*ao, c32*ao.
  word_t szt, ys, c34ao, c32ao;
  word_t zt1_b [ML], vz_b [ML], xs_b [ML], ao_b [ML], bo_b [ML];
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_szt (.clk_i, .en_i(en), .a_i(shv_q), .b_i(zt1), .p_o(szt));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_ys (.clk_i, .en_i(en), .a_i(ysarg), .b_i(Half), .p_o(ys));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_c34 (.clk_i, .en_i(en), .a_i(C34), .b_i(ao), .p_o(c34ao));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_c32 (.clk_i, .en_i(en), .a_i(C32), .b_i(ao), .p_o(c32ao));
  always_ff @(posedge clk_i) begin
    if (en) begin
      zt1_b[0] <= zt1;
      vz_b[0]  <= vz_a_q[ML-1];
      xs_b[0]  <= xs;
      ao_b[0]  <= ao;
      bo_b[0]  <= bo;
      for (int i = 1; i < ML; i++) begin
        zt1_b[i] <= zt1_b[i-1];
        vz_b[i]  <= vz_b[i-1];
        xs_b[i]  <= xs_b[i-1];
        ao_b[i]  <= ao_b[i-1];
        bo_b[i]  <= bo_b[i-1];
      end
    end
  end

  word_t zyt;
  assign zyt = sadd(szt, vz_b[ML-1]);

  // Stage C (TZ2 -> TZ3): tqv*zyt, tqp*ys, (c34*ao)*dt.
  word_t tzy, tys, drift;
  word_t zt1_c [ML], zyt_c [ML], xs_c [ML], ys_c [ML], ao_c [ML], bo_c [ML], c32_c [ML];
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_tzy (.clk_i, .en_i(en), .a_i(tqv_q), .b_i(zyt), .p_o(tzy));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_tys (.clk_i, .en_i(en), .a_i(tqp_q), .b_i(ys), .p_o(tys));
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_dr (.clk_i, .en_i(en), .a_i(c34ao), .b_i(dt_w), .p_o(drift));
  always_ff @(posedge clk_i) begin
    if (en) begin
      zt1_c[0] <= zt1_b[ML-1];
      zyt_c[0] <= zyt;
      xs_c[0]  <= xs_b[ML-1];
      ys_c[0]  <= ys;
      ao_c[0]  <= ao_b[ML-1];
      bo_c[0]  <= bo_b[ML-1];
      c32_c[0] <= c32ao;
      for (int i = 1; i < ML; i++) begin
        zt1_c[i] <= zt1_c[i-1];
        zyt_c[i] <= zyt_c[i-1];
        xs_c[i]  <= xs_c[i-1];
        ys_c[i]  <= ys_c[i-1];
        ao_c[i]  <= ao_c[i-1];
        bo_c[i]  <= bo_c[i-1];
        c32_c[i] <= c32_c[i-1];
      end
    end
  end

  word_t zxt, xst1;
  assign zxt  = ssub(zt1_c[ML-1], tzy);
  assign xst1 = ssub(xs_c[ML-1], tys);

  // Stage D (TZ3 -> TP2): shp*xst1.
  word_t sxs;
  word_t xst1_d [ML], ys_d [ML], ao_d [ML], bo_d [ML], c32_d [ML], dr_d [ML], zyt_d [ML];
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_sxs (.clk_i, .en_i(en), .a_i(shp_q), .b_i(xst1), .p_o(sxs));
  always_ff @(posedge clk_i) begin
    if (en) begin
      xst1_d[0] <= xst1;
      ys_d[0]   <= ys_c[ML-1];
      ao_d[0]   <= ao_c[ML-1];
      bo_d[0]   <= bo_c[ML-1];
      c32_d[0]  <= c32_c[ML-1];
      dr_d[0]   <= drift;
      zyt_d[0]  <= zyt_c[ML-1];
      for (int i = 1; i < ML; i++) begin
        xst1_d[i] <= xst1_d[i-1];
        ys_d[i]   <= ys_d[i-1];
        ao_d[i]   <= ao_d[i-1];
        bo_d[i]   <= bo_d[i-1];
        c32_d[i]  <= c32_d[i-1];
        dr_d[i]   <= dr_d[i-1];
        zyt_d[i]  <= zyt_d[i-1];
      end
    end
  end

  word_t yst;
  assign yst = sadd(sxs, ys_d[ML-1]);

  // Stage E (TP2 -> TP3): tqp*yst.
  word_t tyst;
  word_t xst1_e [ML], yst_e [ML], ao_e [ML], bo_e [ML], c32_e [ML], dr_e [ML], zyt_e [ML];
  epu_fmul #(.FRAC_BITS(FRAC_BITS)) u_tyst (.clk_i, .en_i(en), .a_i(tqp_q), .b_i(yst), .p_o(tyst));
  always_ff @(posedge clk_i) begin
    if (en) begin
      xst1_e[0] <= xst1_d[ML-1];
      yst_e[0]  <= yst;
      ao_e[0]   <= ao_d[ML-1];
      bo_e[0]   <= bo_d[ML-1];
      c32_e[0]  <= c32_d[ML-1];
      dr_e[0]   <= dr_d[ML-1];
      zyt_e[0]  <= zyt_d[ML-1];
      for (int i = 1; i < ML; i++) begin
        xst1_e[i] <= xst1_e[i-1];
        yst_e[i]  <= yst_e[i-1];
        ao_e[i]   <= ao_e[i-1];
        bo_e[i]   <= bo_e[i-1];
        c32_e[i]  <= c32_e[i-1];
        dr_e[i]   <= dr_e[i-1];
        zyt_e[i]  <= zyt_e[i-1];
      end
    end
  end

  word_t xst, nx_num, ny_num, vy_new;
  assign xst    = ssub(xst1_e[ML-1], tyst);
  assign nx_num = sadd(xst, ao_e[ML-1]);
  assign ny_num = sadd(dbl(yst_e[ML-1]), bo_e[ML-1]);
  assign vy_new = ssub(ssub('0, dbl(xst)), c32_e[ML-1]);

  // The vertical quotient starts earlier; its result is delayed to line up.
  localparam int unsigned ZW = TP3 - TZ3;
  word_t zq, nxq, nyq;
  word_t zq_f [ZW];
  word_t vx_f [DL], vy_f [DL], vz_f [DL], dr_f [DL];
  epu_fdiv #(.FRAC_BITS(FRAC_BITS)) u_dz (.clk_i, .en_i(en), .num_i(zxt), .den_i(vert_q), .q_o(zq));
  epu_fdiv #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk_i, .en_i(en), .num_i(nx_num), .den_i(orbit_q),
                                          .q_o(nxq));
  epu_fdiv #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk_i, .en_i(en), .num_i(ny_num), .den_i(orbit_q),
                                          .q_o(nyq));
  always_ff @(posedge clk_i) begin
    if (en) begin
      zq_f[0] <= zq;
      for (int i = 1; i < ZW; i++) zq_f[i] <= zq_f[i-1];
      vx_f[0] <= yst_e[ML-1];
      vy_f[0] <= vy_new;
      vz_f[0] <= zyt_e[ML-1];
      dr_f[0] <= dr_e[ML-1];
      for (int i = 1; i < DL; i++) begin
        vx_f[i] <= vx_f[i-1];
        vy_f[i] <= vy_f[i-1];
        vz_f[i] <= vz_f[i-1];
        dr_f[i] <= dr_f[i-1];
      end
    end
  end

  assign new_pos_x_o = nxq;
  assign new_pos_y_o = ssub(nyq, dr_f[DL-1]);
  assign new_pos_z_o = zq_f[ZW-1];
  assign new_vel_x_o = vx_f[DL-1];
  assign new_vel_y_o = vy_f[DL-1];
  assign new_vel_z_o = vz_f[DL-1];

  ap_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_pos_x_o))
    else $error("result changed while stalled");
  ap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output side");
  ap_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction lost its valid bit");
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for epicycle_particle_update: drives particles and register
// writes over valid/ready channels and checks every result against a local predictor.
// Depends on epu_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
  import epu_pkg::*;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct {
    logic  opcode;
    word_t px, py, pz, vx, vy, vz, ax, ay, az;
  } particle_t;

  typedef struct {
    word_t px, py, pz, vx, vy, vz;
  } motion_t;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int DrainCycles = 300;
  localparam int StallLimit  = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [WordW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = 1'b0;
  word_t pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  word_t vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  word_t acc_x_i = '0, acc_y_i = '0, acc_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  word_t new_pos_x_o, new_pos_y_o, new_pos_z_o;
  word_t new_vel_x_o, new_vel_y_o, new_vel_z_o;

  epicycle_particle_update DUT (.*);

  // Predictor copy of the register file.
  logic [RateW-1:0] orbit_q = 63'd1 << FracBits;
  logic [RateW-1:0] vert_q  = 63'd1 << FracBits;
  logic [RateW-1:0] dt_q    = '0;
  word_t sin_p_q = '0, tan_p_q = '0, sin_v_q = '0, tan_v_q = '0;

  motion_t expected_motion[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int send_gap_max = 16;
  int recv_gap_max = 16;
  int hold_request = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] magnitude(word_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic word_t saturate(logic [127:0] m, logic neg);
    if (!neg) return (m > 128'(SMax)) ? SMax : word_t'(m[63:0]);
    if (m > (128'd1 << 63)) return SMin;
    return word_t'(~m[63:0] + 64'd1);
  endfunction

  function automatic word_t fx_mul(word_t a, word_t b);
    logic [127:0] p;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    p = (p + (128'd1 << (FracBits - 1))) >> FracBits;
    return saturate(p, a[63] != b[63]);
  endfunction

  function automatic word_t fx_div(word_t num, logic [RateW-1:0] rate);
    logic [127:0] n, d, q, r;
    if (rate == '0) begin
      if (num == 0) return '0;
      return num[63] ? SMin : SMax;
    end
    n = {64'd0, magnitude(num)} << FracBits;
    d = {65'd0, rate};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 128'd1;
    return saturate(q, num[63]);
  endfunction

  function automatic motion_t advance_particle(particle_t p);
    motion_t m;
    word_t dt, vx, vy, vz, zt1, zyt, zxt, xo, yo, ao, bo, xs, ys, xst1, yst, xst;
    dt = word_t'({1'b0, dt_q});
    vx = p.vx; vy = p.vy; vz = p.vz;
    if (p.opcode) begin
      vx = sadd(vx, fx_mul(p.ax, dt));
      vy = sadd(vy, fx_mul(p.ay, dt));
      vz = sadd(vz, fx_mul(p.az, dt));
    end
    zt1 = ssub(fx_mul(p.pz, word_t'({1'b0, vert_q})), fx_mul(tan_v_q, vz));
    zyt = sadd(fx_mul(sin_v_q, zt1), vz);
    zxt = ssub(zt1, fx_mul(tan_v_q, zyt));
    m.pz = fx_div(zxt, vert_q);
    m.vz = zyt;

    xo = fx_mul(p.px, word_t'({1'b0, orbit_q}));
    yo = fx_mul(p.py, word_t'({1'b0, orbit_q}));
    ao = sadd(dbl(vy), dbl(dbl(xo)));
    bo = ssub(yo, dbl(vx));
    ys = fx_mul(ssub(yo, bo), word_t'(64'd1 << (FracBits - 1)));
    xs = ssub(xo, ao);
    xst1 = ssub(xs, fx_mul(tan_p_q, ys));
    yst = sadd(fx_mul(sin_p_q, xst1), ys);
    xst = ssub(xst1, fx_mul(tan_p_q, yst));
    m.px = fx_div(sadd(xst, ao), orbit_q);
    m.py = ssub(fx_div(sadd(dbl(yst), bo), orbit_q),
                fx_mul(fx_mul(word_t'(64'd3 << (FracBits - 2)), ao), dt));
    m.vx = yst;
    m.vy = ssub(ssub('0, dbl(xst)), fx_mul(word_t'(64'd3 << (FracBits - 1)), ao));
    return m;
  endfunction

  function automatic word_t sign_extend(logic [63:0] v, int w);
    logic [63:0] m, s;
    m = (64'd1 << w) - 64'd1;
    s = 64'd1 << (w - 1);
    return word_t'(((v & m) ^ s) - s);
  endfunction

  // Mix of full-range, scaled-down and boundary values.
  function automatic word_t random_word();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: w = w;
      1: case ($urandom_range(0, 5))
           0: w = SMax; 1: w = SMin; 2: w = '0; 3: w = 64'sd1; 4: w = -64'sd1;
           default: w = word_t'(64'd1 << FracBits);
         endcase
      default: w = w >>> $urandom_range(12, 60);
    endcase
    return w;
  endfunction

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegOrbitRate: orbit_q = data[RateW-1:0];
      RegVertRate:  vert_q  = data[RateW-1:0];
      RegStepTime:  dt_q    = data[RateW-1:0];
      RegSinHalfP:  sin_p_q = sign_extend(data, 34);
      RegTanQuartP: tan_p_q = sign_extend(data, 36);
      RegSinHalfV:  sin_v_q = sign_extend(data, 34);
      RegTanQuartV: tan_v_q = sign_extend(data, 36);
      default: ;
    endcase
  endtask

  // Loads a physically consistent setting from rates and a step, all in real units.
  task automatic load_orbit(real w, real wz, real dt);
    real s;
    s = 2.0 ** FracBits;
    write_register(RegOrbitRate, 64'(longint'(w * s)));
    write_register(RegVertRate, 64'(longint'(wz * s)));
    write_register(RegStepTime, 64'(longint'(dt * s)));
    write_register(RegSinHalfP, 64'(longint'($sin(-w * dt / 2.0) * s)));
    write_register(RegTanQuartP, 64'(longint'($tan(-w * dt / 4.0) * s)));
    write_register(RegSinHalfV, 64'(longint'($sin(-wz * dt / 2.0) * s)));
    write_register(RegTanQuartV, 64'(longint'($tan(-wz * dt / 4.0) * s)));
  endtask

  // Called right at a clock edge. Valid stays high between back-to-back transactions;
  // it drops only for a gap.
  task automatic send_particle(particle_t p);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= p.opcode;
    pos_x_i <= p.px; pos_y_i <= p.py; pos_z_i <= p.pz;
    vel_x_i <= p.vx; vel_y_i <= p.vy; vel_z_i <= p.vz;
    acc_x_i <= p.ax; acc_y_i <= p.ay; acc_z_i <= p.az;
    do @(posedge clk_i); while (!in_ready_o);
    expected_motion.push_back(advance_particle(p));
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic particle_t random_particle();
    particle_t p;
    p.opcode = $urandom_range(0, 1);
    p.px = random_word(); p.py = random_word(); p.pz = random_word();
    p.vx = random_word(); p.vy = random_word(); p.vz = random_word();
    p.ax = random_word(); p.ay = random_word(); p.az = random_word();
    return p;
  endfunction

  function automatic particle_t uniform_particle(word_t v, logic op);
    particle_t p;
    p.opcode = op;
    p.px = v; p.py = v; p.pz = v; p.vx = v; p.vy = v; p.vz = v;
    p.ax = v; p.ay = v; p.az = v;
    return p;
  endfunction

  task automatic test_reset_defaults();
    send_particle(uniform_particle(word_t'(64'd3 << FracBits), 1'b1));
    send_particle(uniform_particle(-64'sd12345, 1'b0));
    drain();
  endtask

  task automatic test_extremes();
    particle_t p;
    load_orbit(1.0, 1.3, 0.01);
    send_particle(uniform_particle(SMax, 1'b1));
    send_particle(uniform_particle(SMin, 1'b1));
    send_particle(uniform_particle(SMax, 1'b0));
    send_particle(uniform_particle(SMin, 1'b0));
    send_particle(uniform_particle('0, 1'b1));
    send_particle(uniform_particle(-64'sd1, 1'b1));
    p = uniform_particle(SMax, 1'b1);
    p.vx = SMin; p.ay = SMin; p.pz = SMin;
    send_particle(p);
    // Alternating bit patterns cover every input bit at both values.
    send_particle(uniform_particle(word_t'(64'h5555_5555_5555_5555), 1'b1));
    send_particle(uniform_particle(word_t'(64'hAAAA_AAAA_AAAA_AAAA), 1'b0));
    drain();
  endtask

  task automatic test_register_corners();
    // Upper data bits must be masked off, and the unused index must be ignored.
    write_register(RegOrbitRate, 64'h8000_0000_0000_0000);
    write_register(RegVertRate, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(RegStepTime, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(RegSinHalfP, 64'hFFFF_FFFE_0000_0000);
    write_register(RegTanQuartP, 64'h0000_000C_0000_0001);
    write_register(RegSinHalfV, 64'h0000_0001_0000_0000);
    write_register(RegTanQuartV, 64'hFFFF_FFFC_0000_0000);
    write_register(RegUnused, 64'h1234_5678_9ABC_DEF0);
    send_particle(uniform_particle(word_t'(64'd7 << FracBits), 1'b1));
    send_particle(uniform_particle(-64'sd99, 1'b0));
    send_particle(uniform_particle('0, 1'b1));
    send_particle(random_particle());
    drain();
    write_register(RegOrbitRate, 64'd1);
    write_register(RegVertRate, 64'd1);
    write_register(RegStepTime, 64'd0);
    send_particle(uniform_particle(word_t'(64'd1 << FracBits), 1'b1));
    send_particle(random_particle());
    drain();
  endtask

  task automatic random_phase(int count);
    repeat (count) send_particle(random_particle());
    drain();
  endtask

  task automatic test_random_settings();
    load_orbit(1.0, 1.0, 0.001);
    random_phase(300);
    load_orbit(0.25, 2.0, 0.5);
    send_gap_max = 0;
    recv_gap_max = 0;
    random_phase(300);
    send_gap_max = 16;
    recv_gap_max = 16;
    write_register(RegOrbitRate, {$urandom, $urandom});
    write_register(RegVertRate, {$urandom, $urandom});
    write_register(RegStepTime, {$urandom, $urandom});
    write_register(RegSinHalfP, {$urandom, $urandom});
    write_register(RegTanQuartP, {$urandom, $urandom});
    write_register(RegSinHalfV, {$urandom, $urandom});
    write_register(RegTanQuartV, {$urandom, $urandom});
    random_phase(300);
    load_orbit(3.0, 0.5, 1.0);
    random_phase(300);
  endtask

  task automatic test_output_backpressure();
    load_orbit(1.0, 1.7, 0.05);
    send_gap_max = 0;
    hold_request = 600;
    random_phase(400);
    send_gap_max = 16;
  endtask

  // Result checker and receiver-side ready control.
  initial begin
    motion_t e;
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        received++;
        stall_left = $urandom_range(0, recv_gap_max);
        if (expected_motion.size() == 0) begin
          $display("%0t: result with no particle outstanding", $time);
          errors++;
        end else begin
          e = expected_motion.pop_front();
          if (new_pos_x_o !== e.px) begin
            $display("%0t: new_pos_x exp %h got %h", $time, e.px, new_pos_x_o); errors++;
          end
          if (new_pos_y_o !== e.py) begin
            $display("%0t: new_pos_y exp %h got %h", $time, e.py, new_pos_y_o); errors++;
          end
          if (new_pos_z_o !== e.pz) begin
            $display("%0t: new_pos_z exp %h got %h", $time, e.pz, new_pos_z_o); errors++;
          end
          if (new_vel_x_o !== e.vx) begin
            $display("%0t: new_vel_x exp %h got %h", $time, e.vx, new_vel_x_o); errors++;
          end
          if (new_vel_y_o !== e.vy) begin
            $display("%0t: new_vel_y exp %h got %h", $time, e.vy, new_vel_y_o); errors++;
          end
          if (new_vel_z_o !== e.vz) begin
            $display("%0t: new_vel_z exp %h got %h", $time, e.vz, new_vel_z_o); errors++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_register_corners();
    test_random_settings();
    test_output_backpressure();
    $display("Covered %0d particles and %0d results over reset, extreme, masked and",
             sent, received);
    $display("physical register settings, with random gaps and a long output stall.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
